### rtl/core/lbm_pkg.sv
// Shared types, constants and helpers for the D2Q9 BGK collision block.
// Used by the moment front end, the per-direction lanes, the merge stage and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package lbm_pkg;

  localparam int NDIR    = 9;
  localparam int DATA_W  = 32;
  localparam int OMEGA_W = 30;
  localparam int NSUM    = 3;

  // Pipeline depth: the moment front end, then the lanes.
  localparam int MOM_LAT    = 4;
  localparam int LANE_LAT   = 9;
  localparam int PIPE_DEPTH = MOM_LAT + LANE_LAT;

  localparam int IN_W  = NDIR * DATA_W;
  localparam int OUT_W = (NDIR + NSUM) * DATA_W;

  // Lattice velocity components and weight shifts per direction.
  // The weights 4/36, 1/36 and 16/36 are applied as left shifts by 2, 0 and 4.
  localparam int DIR_CX [NDIR] = '{-1, 1, 0, 0, 1, 1, -1, -1, 0};
  localparam int DIR_CY [NDIR] = '{0, 0, -1, 1, 1, -1, -1, 1, 0};
  localparam int W_SHIFT [NDIR] = '{2, 2, 2, 2, 0, 0, 0, 0, 4};

  // Equilibrium division: floor((w*t + 18) / 36) is done as a shift by two and
  // an exact divide by nine. The dividend is biased by 9 * 2^31 to be unsigned.
  localparam logic signed [41:0] FEQ_HALF  = 42'sd18;
  localparam logic signed [39:0] FEQ_BIAS  = 40'sd19327352832;
  localparam logic [18:0]        RECIP_HI  = 19'd466034;   // ceil(2^22 / 9)
  localparam logic [22:0]        RECIP_LO  = 23'd7456541;  // ceil(2^26 / 9)
  localparam int                 RECIP_HI_SH = 22;
  localparam int                 RECIP_LO_SH = 26;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  // Exact moments, with the momenta already multiplied by three.
  typedef struct packed {
    logic signed [35:0] rho;
    logic signed [36:0] m3x;
    logic signed [36:0] m3y;
  } mom_t;

  // Saturated moments as they leave the block.
  typedef struct packed {
    word_t momentum_y;
    word_t momentum_x;
    word_t density;
  } summary_t;

  // Pipeline control handed to the merge stage.
  typedef struct packed {
    logic ce;
    logic push;
  } pipe_ctl_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = WORD_MAX;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r = WORD_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/lbm_moments.sv
// Moment front end: density and x/y momentum of one cell over four stages.
// Depends on lbm_pkg.
`timescale 1ns / 1ps

module lbm_moments
  import lbm_pkg::*;
(
  input  logic     clk,
  input  logic     ce,
  input  word_t    f_in [NDIR],
  output word_t    f_out [NDIR],
  output mom_t     mom,
  output summary_t summary
);

  word_t f1 [NDIR];
  word_t f2 [NDIR];
  word_t f3 [NDIR];

  logic signed [33:0] sxp, sxn, syp, syn, srest;
  logic signed [33:0] sxp_next, sxn_next, syp_next, syn_next, srest_next;
  logic signed [35:0] rho, rho_next;
  logic signed [34:0] mx, my, mx_next, my_next;
  mom_t               mom_next;
  summary_t           summary_next;

  // Partial sums of three, grouped so both momenta and the density reuse them.
  always_comb begin
    sxp_next   = 34'(f1[1]) + 34'(f1[4]) + 34'(f1[5]);
    sxn_next   = 34'(f1[0]) + 34'(f1[6]) + 34'(f1[7]);
    syp_next   = 34'(f1[3]) + 34'(f1[4]) + 34'(f1[7]);
    syn_next   = 34'(f1[2]) + 34'(f1[5]) + 34'(f1[6]);
    srest_next = 34'(f1[2]) + 34'(f1[3]) + 34'(f1[8]);
  end

  always_comb begin
    rho_next = 36'(sxp) + 36'(sxn) + 36'(srest);
    mx_next  = 35'(sxp) - 35'(sxn);
    my_next  = 35'(syp) - 35'(syn);
  end

  always_comb begin
    mom_next.rho = rho;
    mom_next.m3x = 37'(mx) + (37'(mx) <<< 1);
    mom_next.m3y = 37'(my) + (37'(my) <<< 1);
    summary_next.density    = sat32(64'(rho));
    summary_next.momentum_x = sat32(64'(mx));
    summary_next.momentum_y = sat32(64'(my));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1      <= f_in;
      f2      <= f1;
      f3      <= f2;
      f_out   <= f3;
      sxp     <= sxp_next;
      sxn     <= sxn_next;
      syp     <= syp_next;
      syn     <= syn_next;
      srest   <= srest_next;
      rho     <= rho_next;
      mx      <= mx_next;
      my      <= my_next;
      mom     <= mom_next;
      summary <= summary_next;
    end
  end

endmodule

### rtl/core/lbm_lane.sv
// One collision lane: equilibrium and BGK relaxation for a single direction.
// Depends on lbm_pkg; the direction is fixed by the DIR parameter.
`timescale 1ns / 1ps

module lbm_lane
  import lbm_pkg::*;
#(
  parameter int DIR       = 0,
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               ce,
  input  mom_t               mom,
  input  word_t              f_in,
  input  logic [OMEGA_W-1:0] omega,
  output word_t              f_out
);

  localparam int CX = DIR_CX[DIR];
  localparam int CY = DIR_CY[DIR];
  localparam int SH = W_SHIFT[DIR];
  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [1:0] {CLIP_NONE, CLIP_HIGH, CLIP_LOW} clip_t;

  // Distribution delayed alongside stages one to eight.
  word_t f_dly [LANE_LAT-1];

  logic signed [37:0] vx, vy, t, t_next;
  logic signed [41:0] x;
  logic signed [39:0] u, y;
  clip_t              clip_next, clip2, clip3, clip4, clip5;
  logic [17:0]        yh_next, yh2, yh3;
  logic [17:0]        yl_next, yl2, yl3;
  logic [36:0]        p1, p1_next;
  logic [14:0]        qh_next, qh4, qh5;
  logic [17:0]        nine_qh;
  logic [3:0]         rh;
  logic [21:0]        z, z_next;
  logic [44:0]        p2, p2_next;
  logic [17:0]        ql;
  logic [32:0]        q;
  word_t              feq;
  logic signed [32:0] d, d_next;
  logic signed [63:0] prod, prod_next;
  logic signed [63:0] r, r_next;
  logic signed [63:0] delta, sum;

  // Stage 1: t = rho + 3 * (cx*mx + cy*my), with mx and my the momenta.
  always_comb begin
    vx = '0;
    vy = '0;
    if (CX > 0) begin
      vx = 38'(mom.m3x);
    end else if (CX < 0) begin
      vx = -38'(mom.m3x);
    end
    if (CY > 0) begin
      vy = 38'(mom.m3y);
    end else if (CY < 0) begin
      vy = -38'(mom.m3y);
    end
    t_next = 38'(mom.rho) + vx + vy;
  end

  // Stage 2: weight, divide by four, range check and bias for the divide by nine.
  always_comb begin
    x = (42'(t) <<< SH) + FEQ_HALF;
    u = 40'(x >>> 2);
    y = u + FEQ_BIAS;
    if (u >= FEQ_BIAS) begin
      clip_next = CLIP_HIGH;
    end else if (u < -FEQ_BIAS) begin
      clip_next = CLIP_LOW;
    end else begin
      clip_next = CLIP_NONE;
    end
    yh_next = y[35:18];
    yl_next = y[17:0];
  end

  // Stages 3 to 5: divide by nine in two halves, each by a reciprocal multiply.
  assign p1_next = yh2 * RECIP_HI;

  always_comb begin
    qh_next = p1[RECIP_HI_SH +: 15];
    nine_qh = {qh_next, 3'b000} + {3'b000, qh_next};
    rh      = 4'(yh3 - nine_qh);
    z_next  = {rh, yl3};
  end

  assign p2_next = z * RECIP_LO;

  // Stage 6: rebuild the quotient, remove the bias, clip, and form feq - f.
  always_comb begin
    ql = p2[RECIP_LO_SH +: 18];
    q  = {qh5, ql};
    unique case (clip5)
      CLIP_HIGH: feq = WORD_MAX;
      CLIP_LOW:  feq = WORD_MIN;
      CLIP_NONE: feq = {~q[31], q[30:0]};
      default:   feq = {~q[31], q[30:0]};
    endcase
    d_next = 33'(feq) - 33'(f_dly[4]);
  end

  // Stages 7 to 9: relax toward equilibrium with rounding, then saturate.
  assign prod_next = d * $signed({1'b0, omega});
  assign r_next    = prod + RND;

  always_comb begin
    delta = r >>> FRAC_BITS;
    sum   = 64'(f_dly[7]) + delta;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f_dly[0] <= f_in;
      for (int k = 1; k < LANE_LAT - 1; k++) begin
        f_dly[k] <= f_dly[k-1];
      end
      t     <= t_next;
      clip2 <= clip_next;
      yh2   <= yh_next;
      yl2   <= yl_next;
      clip3 <= clip2;
      p1    <= p1_next;
      yh3   <= yh2;
      yl3   <= yl2;
      clip4 <= clip3;
      qh4   <= qh_next;
      z     <= z_next;
      clip5 <= clip4;
      qh5   <= qh4;
      p2    <= p2_next;
      d     <= d_next;
      prod  <= prod_next;
      r     <= r_next;
      f_out <= sat32(sum);
    end
  end

endmodule

### rtl/core/lbm_merge.sv
// Merge stage: aligns the moments with the lane results and holds the
// finished request in a two-entry output skid buffer. Depends on lbm_pkg.
`timescale 1ns / 1ps

module lbm_merge
  import lbm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  pipe_ctl_t        ctl,
  input  summary_t         summary_in,
  input  word_t            dist_in [NDIR],
  output logic             ready,
  input  logic             m_axis_tready,
  output logic             m_axis_tvalid,
  output logic [OUT_W-1:0] m_axis_tdata
);

  summary_t         sum_dly [LANE_LAT];
  logic [OUT_W-1:0] item_next;
  logic [OUT_W-1:0] spare_data;
  logic             spare_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (ctl.ce) begin
      sum_dly[0] <= summary_in;
      for (int k = 1; k < LANE_LAT; k++) begin
        sum_dly[k] <= sum_dly[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NDIR; i++) begin
      item_next[i*DATA_W +: DATA_W] = dist_in[i];
    end
    item_next[NDIR*DATA_W +: NSUM*DATA_W] = {sum_dly[LANE_LAT-1].momentum_y,
                                             sum_dly[LANE_LAT-1].momentum_x,
                                             sum_dly[LANE_LAT-1].density};
  end

  assign pop   = m_axis_tvalid & m_axis_tready;
  assign ready = ~spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      spare_valid   <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        spare_valid <= 1'b0;
      end else begin
        m_axis_tvalid <= ctl.push;
      end
    end else if (ctl.push) begin
      if (!m_axis_tvalid) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (spare_valid) begin
        m_axis_tdata <= spare_data;
      end else if (ctl.push) begin
        m_axis_tdata <= item_next;
      end
    end else if (ctl.push) begin
      if (!m_axis_tvalid) begin
        m_axis_tdata <= item_next;
      end else begin
        spare_data <= item_next;
      end
    end
  end

endmodule

### rtl/core/lattice_d2q9_bgk_collision.sv
// D2Q9 lattice Boltzmann BGK collision for one cell per request.
//
// The slave stream carries the nine distributions of one cell; the master
// stream returns the nine post-collision distributions followed by the
// saturated density and the x and y momentum. All values are signed fixed
// point with FRAC_BITS fraction bits. The relaxation rate omega is written
// through cfg_wr_en / cfg_wr_data and must only change while no request is
// in flight. Reset sets omega to 1.0 and empties the pipeline and the
// output buffer; after reset the block is ready at once.
//
// Throughput is one request per clock cycle while the spare entry is free.
// The edge that accepts a request loads the first of four stages that form
// the moments; nine lane stages then form the equilibrium (two reciprocal
// multiplies for the divide by nine) and the omega relaxation, and the
// output register is loaded last.
// When the receiver stalls, the output register and a spare entry absorb
// results; once the spare entry is taken the whole pipeline holds and
// s_axis_tready drops until the receiver takes a result.
`timescale 1ns / 1ps

module lattice_d2q9_bgk_collision
  import lbm_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration: omega, unsigned with FRAC_BITS fraction bits.
  input  logic               cfg_wr_en,
  input  logic [OMEGA_W-1:0] cfg_wr_data,
  // Input request.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // Fields from bit 0 up: dist_in_0 .. dist_in_8, 32 bits each.
  input  logic [IN_W-1:0]    s_axis_tdata,
  // Result.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // Fields from bit 0 up: dist_out_0 .. dist_out_8, density, momentum_x,
  // momentum_y, 32 bits each.
  output logic [OUT_W-1:0]   m_axis_tdata
);

  // Omega resets to 1.0, or to the largest code if 1.0 does not fit.
  localparam logic [63:0] ONE_Q       = 64'd1 << FRAC_BITS;
  localparam logic [63:0] OMEGA_MAX   = (64'd1 << OMEGA_W) - 64'd1;
  localparam logic [63:0] OMEGA_RST_W = (ONE_Q > OMEGA_MAX) ? OMEGA_MAX : ONE_Q;

  logic [OMEGA_W-1:0]    omega;
  logic [PIPE_DEPTH-1:0] vld;
  logic                  ce;
  pipe_ctl_t             ctl;
  word_t                 f_in [NDIR];
  word_t                 f_mom [NDIR];
  word_t                 dist_out [NDIR];
  mom_t                  mom;
  summary_t              summary;

  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= OMEGA_RST_W[OMEGA_W-1:0];
    end else if (cfg_wr_en) begin
      omega <= cfg_wr_data;
    end
  end

  // The whole pipeline advances together whenever the output side has room.
  assign s_axis_tready = ce;
  assign ctl.ce        = ce;
  assign ctl.push      = vld[PIPE_DEPTH-1] & ce;

  // One valid bit per stage; the payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < NDIR; i++) begin
      f_in[i] = s_axis_tdata[i*DATA_W +: DATA_W];
    end
  end

  lbm_moments u_moments (
    .clk     (clk),
    .ce      (ce),
    .f_in    (f_in),
    .f_out   (f_mom),
    .mom     (mom),
    .summary (summary)
  );

  // One lane per lattice direction, all fed by the same moments.
  for (genvar g = 0; g < NDIR; g++) begin : g_lane
    lbm_lane #(
      .DIR       (g),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .ce    (ce),
      .mom   (mom),
      .f_in  (f_mom[g]),
      .omega (omega),
      .f_out (dist_out[g])
    );
  end

  lbm_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .summary_in    (summary),
    .dist_in       (dist_out),
    .ready         (ce),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A held pipeline must not lose or create requests.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> $stable(vld))
    else $error("pipeline valid bits moved while stalled");

  // A request leaving the last lane stage must reach the output register.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (vld[PIPE_DEPTH-1] && s_axis_tready) |=> m_axis_tvalid)
    else $error("result pushed but output not valid");

  // The spare entry is only used behind a full output register.
  a_spare_behind_main: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("spare entry full while output register empty");

endmodule
